### sv/bmorph_pkg.sv
package bmorph_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_PASSES = 4;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 12;
  localparam int ROW_W      = HGT_W + 1;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PASS_W     = 2;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE         = 3'd0,
    REG_BIG_KERNEL   = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_BORDER_VALUE = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } pos_t;

  // Per-pass control handed from the accept cycle to the line store cycle.
  typedef struct packed {
    logic             act;
    logic             top_ok;
    logic             mid_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic             q_ok;
    logic             use_or;
    logic             fwd;
    logic [COL_W-1:0] addr;
  } pass_ctl_t;

  function automatic pos_t pos_adv(pos_t p, logic [COL_W-1:0] last_col);
    pos_t r;
    if (p.col == last_col) begin
      r.col = '0;
      r.row = p.row + ROW_W'(1);
    end else begin
      r.col = p.col + COL_W'(1);
      r.row = p.row;
    end
    return r;
  endfunction

  function automatic logic pass_is_or(mode_t m, logic big, logic [PASS_W-1:0] s);
    logic first;
    logic r;
    first = big ? (s < PASS_W'(2)) : (s == PASS_W'(0));
    unique case (m)
      MODE_ERODE:  r = 1'b0;
      MODE_DILATE: r = 1'b1;
      MODE_OPEN:   r = !first;
      MODE_CLOSE:  r = first;
      default:     r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### sv/binary_morphology_3x3_stream.sv
// Binary 3x3 morphology on a raster pixel stream. Each pass is a separable
// 3x3 AND (erode) or OR (dilate); open and close chain two operations and
// the big kernel setting doubles each operation, for 1, 2 or 4 passes. The
// block takes one request per clock while in_stall is low: an input request
// is processed as counter update and line store read, then combine and write
// back, and the next request may enter on the following clock. A result leaves
// P*(width+1) requests after its pixel entered, so drain requests
// (operation=1) push the frame tail out; a drain request that arrives while
// frame pixels are still due is dropped, and a pixel request after the last
// frame pixel acts as a drain. Each pass owns one line store of MAX_WIDTH
// words that hold the two previous rows per column; a column written by one
// request and read by the next is forwarded. Results go through a four-entry
// output queue, so the input is only stalled when the output side is stalled.
// Any write to a listed register aborts the frame in flight; a write to an
// index past the list does nothing. Write only while idle.
module binary_morphology_3x3_stream (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_operation,
  input  logic [bmorph_pkg::PIX_W-1:0]        in_pixel_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bmorph_pkg::PIX_W-1:0]        out_pixel_out,
  output logic                                out_frame_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmorph_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmorph_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bmorph_pkg::*;

  // configuration
  mode_t            mode_r;
  logic             big_r;
  logic [WID_W-1:0] width_r;
  logic [HGT_W-1:0] height_r;
  logic [PIX_W-1:0] border_r;
  logic             cfg_wr;
  logic             cfg_hit;

  // effective geometry
  logic [WID_W-1:0]  w_eff;
  logic [COL_W-1:0]  w_last;
  logic [ROW_W-1:0]  h_row;
  pos_t              lag_pos;
  logic [PASS_W-1:0] last_pass;

  // position tracking: slot 0 is the input position, slot j+1 the output
  // position of pass j (which is also the input position of pass j+1)
  pos_t pos_r       [MAX_PASSES+1];
  logic started_r   [MAX_PASSES+1];
  pos_t cur_pos     [MAX_PASSES+1];
  logic act         [MAX_PASSES+1];

  logic accept;
  logic proc;
  logic frame_done;

  pass_ctl_t ctl      [MAX_PASSES];
  pass_ctl_t b_ctl_r  [MAX_PASSES];
  logic             b_valid_r;
  logic [PIX_W-1:0] b_pix_r;
  logic             b_last_r;

  // line store cycle
  wire  [2*PIX_W-1:0] word_raw   [MAX_PASSES];
  logic [2*PIX_W-1:0] fwd_data_r [MAX_PASSES];
  logic [2*PIX_W-1:0] wdata      [MAX_PASSES];
  logic [PIX_W-1:0]   vcomb      [MAX_PASSES];
  logic [PIX_W-1:0]   vd1_r      [MAX_PASSES];
  logic [PIX_W-1:0]   vd2_r      [MAX_PASSES];
  logic [PIX_W-1:0]   val        [MAX_PASSES+1];
  logic               push;
  logic [PIX_W-1:0]   push_pix;

  // output queue
  logic [PIX_W:0]     q_mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] q_wr_r;
  logic [Q_PTR_W-1:0] q_rd_r;
  logic [Q_PTR_W:0]   q_cnt_r;
  logic               pop;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // only a write to a listed register restarts the frame
  assign cfg_hit   = cfg_wr && (cfg_index <= REG_BORDER_VALUE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_ERODE;
      big_r    <= 1'b0;
      width_r  <= WID_W'(640);
      height_r <= HGT_W'(480);
      border_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_MODE:         mode_r   <= mode_t'(cfg_data[1:0]);
        REG_BIG_KERNEL:   big_r    <= cfg_data[0];
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[WID_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[HGT_W-1:0];
        REG_BORDER_VALUE: border_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) begin
      w_eff = WID_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    w_last = COL_W'(w_eff - WID_W'(1));
    h_row  = (height_r == '0) ? ROW_W'(1) : ROW_W'(height_r);
    // the first output of a pass sits width+1 positions behind its input
    if (w_eff == WID_W'(1)) begin
      lag_pos.row = ROW_W'(2);
      lag_pos.col = '0;
    end else begin
      lag_pos.row = ROW_W'(1);
      lag_pos.col = COL_W'(1);
    end
    last_pass = {mode_r[1] & big_r, mode_r[1] | big_r};
  end

  // current positions: a pass output starts when its input hits the lag
  always_comb begin
    act[0]     = 1'b1;
    cur_pos[0] = pos_r[0];
    for (int j = 1; j <= MAX_PASSES; j++) begin
      act[j]     = started_r[j] || (act[j-1] && (cur_pos[j-1] == lag_pos));
      cur_pos[j] = started_r[j] ? pos_r[j] : '0;
    end
  end

  assign in_stall = ((q_cnt_r + (Q_PTR_W+1)'(b_valid_r)) >= (Q_PTR_W+1)'(Q_DEPTH - 1));
  assign accept   = in_valid && !in_stall;
  // drop a drain request while frame pixels are still due
  assign proc     = accept && !((in_operation == OP_DRAIN) && (cur_pos[0].row < h_row));

  always_comb begin
    for (int s = 0; s < MAX_PASSES; s++) begin
      ctl[s].act      = act[s];
      ctl[s].top_ok   = (cur_pos[s].row >= ROW_W'(2)) && (cur_pos[s].row < h_row + ROW_W'(2));
      ctl[s].mid_ok   = (cur_pos[s].row >= ROW_W'(1)) && (cur_pos[s].row < h_row + ROW_W'(1));
      ctl[s].bot_ok   = cur_pos[s].row < h_row;
      ctl[s].left_ok  = cur_pos[s+1].col != '0;
      ctl[s].right_ok = cur_pos[s+1].col != w_last;
      ctl[s].q_ok     = act[s+1] && (cur_pos[s+1].row < h_row);
      ctl[s].use_or   = pass_is_or(mode_r, big_r, PASS_W'(s));
      ctl[s].addr     = cur_pos[s].col;
      // the request in flight writes this column at the same edge
      ctl[s].fwd      = b_valid_r && b_ctl_r[s].act && (b_ctl_r[s].addr == cur_pos[s].col);
    end
  end

  always_comb begin
    frame_done = 1'b0;
    for (int s = 0; s < MAX_PASSES; s++) begin
      if (PASS_W'(s) == last_pass && ctl[s].q_ok &&
          cur_pos[s+1].row == h_row - ROW_W'(1) && cur_pos[s+1].col == w_last) begin
        frame_done = proc;
      end
    end
  end

  // advance the positions; clear them at frame end or on a register write
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit || frame_done) begin
      for (int j = 0; j <= MAX_PASSES; j++) begin
        pos_r[j]     <= '0;
        started_r[j] <= 1'b0;
      end
    end else if (proc) begin
      for (int j = 0; j <= MAX_PASSES; j++) begin
        if (act[j]) begin
          pos_r[j] <= pos_adv(cur_pos[j], w_last);
        end
        started_r[j] <= act[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= proc;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      b_pix_r  <= in_pixel_in;
      b_last_r <= frame_done;
      for (int s = 0; s < MAX_PASSES; s++) begin
        b_ctl_r[s]    <= ctl[s];
        fwd_data_r[s] <= wdata[s];
      end
    end
  end

  // one line store per pass: {row above, row of last write} per column
  for (genvar g = 0; g < MAX_PASSES; g++) begin : g_pass
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_q_r;

    always_ff @(posedge clk) begin
      if (b_valid_r && b_ctl_r[g].act) begin
        mem[b_ctl_r[g].addr] <= wdata[g];
      end
      if (proc) begin
        rd_q_r <= mem[ctl[g].addr];
      end
    end

    assign word_raw[g] = rd_q_r;
  end

  // vertical then horizontal combine, pass after pass
  always_comb begin
    logic [2*PIX_W-1:0] word;
    logic [PIX_W-1:0]   top;
    logic [PIX_W-1:0]   mid;
    logic [PIX_W-1:0]   bot;
    logic [PIX_W-1:0]   left;
    logic [PIX_W-1:0]   right;
    val[0] = b_pix_r;
    for (int s = 0; s < MAX_PASSES; s++) begin
      word     = b_ctl_r[s].fwd ? fwd_data_r[s] : word_raw[s];
      top      = b_ctl_r[s].top_ok ? word[2*PIX_W-1:PIX_W] : border_r;
      mid      = b_ctl_r[s].mid_ok ? word[PIX_W-1:0] : border_r;
      bot      = b_ctl_r[s].bot_ok ? val[s] : border_r;
      vcomb[s] = b_ctl_r[s].use_or ? (top | mid | bot) : (top & mid & bot);
      left     = b_ctl_r[s].left_ok ? vd2_r[s] : border_r;
      right    = b_ctl_r[s].right_ok ? vcomb[s] : border_r;
      val[s+1] = b_ctl_r[s].use_or ? (left | vd1_r[s] | right) : (left & vd1_r[s] & right);
      wdata[s] = {word[PIX_W-1:0], val[s]};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < MAX_PASSES; s++) begin
      if (b_valid_r && b_ctl_r[s].act) begin
        vd2_r[s] <= vd1_r[s];
        vd1_r[s] <= vcomb[s];
      end
    end
  end

  always_comb begin
    push     = 1'b0;
    push_pix = val[MAX_PASSES];
    for (int s = 0; s < MAX_PASSES; s++) begin
      if (PASS_W'(s) == last_pass) begin
        push     = b_valid_r && b_ctl_r[s].q_ok;
        push_pix = val[s+1];
      end
    end
  end

  // output queue
  assign out_valid      = q_cnt_r != '0;
  assign pop            = out_valid && !out_stall;
  assign out_pixel_out  = q_mem[q_rd_r][PIX_W-1:0];
  assign out_frame_last = q_mem[q_rd_r][PIX_W];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[q_wr_r] <= {b_last_r, push_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (push) begin
        q_wr_r <= q_wr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        q_rd_r <= q_rd_r + Q_PTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(pop);
    end
  end

endmodule

### sv/bmorph_checker.sv
module bmorph_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [bmorph_pkg::PIX_W-1:0]      out_pixel_out,
  input logic                              out_frame_last
);
  import bmorph_pkg::*;

  // reset empties the result queue
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  // nothing in flight after reset, so input is open
  assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_out) && $stable(out_frame_last))
    else $error("stalled result changed");

endmodule

bind binary_morphology_3x3_stream bmorph_checker u_bmorph_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pixel_out  (out_pixel_out),
  .out_frame_last (out_frame_last)
);

### verif/binary_morphology_3x3_stream_test.sv
`timescale 1ns / 1ps

module binary_morphology_3x3_stream_test;
  import bmorph_pkg::*;

  localparam int RING_DEPTH = 2 * MAX_WIDTH + 3;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 16;
  // an index past the register list
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } filtered_t;

  // Mirror of the filter chain; holds the expected filtered pixels in order.
  class morph_scoreboard;
    logic [1:0]       mode_q;
    logic             big_q;
    logic [WID_W-1:0] width_q;
    logic [HGT_W-1:0] height_q;
    logic [PIX_W-1:0] border_q;
    logic [PIX_W-1:0] rows[MAX_PASSES][RING_DEPTH];
    int unsigned      frame_pos;
    filtered_t        pending[$];
    int               errors;

    function void clear();
      mode_q = MODE_ERODE;
      big_q = 1'b0;
      width_q = WID_W'(640);
      height_q = HGT_W'(480);
      border_q = '0;
      frame_pos = 0;
      errors = 0;
      pending.delete();
    endfunction

    function int eff_w();
      if (width_q < 1) return 1;
      if (width_q > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_q);
    endfunction

    function int eff_h();
      return (height_q < 1) ? 1 : int'(height_q);
    endfunction

    function int pass_count();
      return (big_q ? 2 : 1) * (mode_q[1] ? 2 : 1);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_MODE:         mode_q = d[1:0];
        REG_BIG_KERNEL:   big_q = d[0];
        REG_IMAGE_WIDTH:  width_q = d[WID_W-1:0];
        REG_IMAGE_HEIGHT: height_q = d[HGT_W-1:0];
        REG_BORDER_VALUE: border_q = d[PIX_W-1:0];
        default:          return;
      endcase
      frame_pos = 0;
    endfunction

    function logic [PIX_W-1:0] neighbor(int s, int r, int c, int w, int h);
      if (r < 0 || r >= h || c < 0 || c >= w) return border_q;
      return rows[s][(r * w + c) % RING_DEPTH];
    endfunction

    function logic is_dilate(int s, int per_op);
      logic first;
      first = s < per_op;
      case (mode_t'(mode_q))
        MODE_ERODE:  return 1'b0;
        MODE_DILATE: return 1'b1;
        MODE_OPEN:   return !first;
        default:     return first;
      endcase
    endfunction

    // Advance the chain by one accepted request.
    function void note_input(logic op, logic [PIX_W-1:0] pix);
      int w, h, n, lag, per_op, passes, k, t, q, r, c;
      logic have, use_or;
      logic [PIX_W-1:0] v, acc;
      filtered_t e;
      w = eff_w();
      h = eff_h();
      n = w * h;
      lag = w + 1;
      per_op = big_q ? 2 : 1;
      passes = pass_count();
      k = frame_pos;
      have = k < n;
      v = pix;
      q = 0;
      if (k < n && op == OP_DRAIN) return;
      for (int s = 0; s < passes; s++) begin
        t = k - s * lag;
        if (have && t >= 0 && t < n) rows[s][t % RING_DEPTH] = v;
        q = t - lag;
        if (q >= 0 && q < n) begin
          r = q / w;
          c = q % w;
          use_or = is_dilate(s, per_op);
          acc = use_or ? 8'h00 : 8'hFF;
          for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
              acc = use_or ? (acc | neighbor(s, r + dr, c + dc, w, h))
                           : (acc & neighbor(s, r + dr, c + dc, w, h));
          v = acc;
          have = 1'b1;
        end else begin
          have = 1'b0;
        end
      end
      frame_pos = (frame_pos + 1) & 32'h7FFFFF;
      if (!have) return;
      e.pixel = v;
      e.last = (q == n - 1);
      if (e.last) frame_pos = 0;
      pending.push_back(e);
    endfunction

    function void check(logic [PIX_W-1:0] pix, logic last);
      filtered_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pixel=%0d last=%0b", $time, pix, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (pix !== e.pixel) begin
        $display("%0t: pixel_out expected %0d actual %0d", $time, e.pixel, pix);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: frame_last expected %0b actual %0b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_operation;
  logic [PIX_W-1:0]      in_pixel_in;
  logic                  out_valid;
  logic                  out_stall;
  logic [PIX_W-1:0]      out_pixel_out;
  logic                  out_frame_last;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  binary_morphology_3x3_stream dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel_out(out_pixel_out), .out_frame_last(out_frame_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  morph_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: stall at random, check every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_pixel_out, out_frame_last);
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog: count cycles where no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("binary_morphology_3x3_stream regression: fail");
        $finish;
      end
    end
  end

  // Present one request; hold it until accepted, then note it.
  task automatic send_request(logic op, logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_pixel_in <= pix;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, pix);
  endtask

  // Drop valid and wait until every expected result is out, then settle.
  task automatic drain_wait();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; valid drops once it is taken.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value, int mask);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(($urandom() & ~mask) | (value & mask));
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic setup(int m, int big, int w, int h, int bv);
    write_reg(REG_MODE, m, 'h3);
    write_reg(REG_BIG_KERNEL, big, 'h1);
    write_reg(REG_IMAGE_WIDTH, w, 'h7FF);
    write_reg(REG_IMAGE_HEIGHT, h, 'hFFF);
    write_reg(REG_BORDER_VALUE, bv, 'hFF);
  endtask

  function automatic logic [PIX_W-1:0] mask_pixel();
    if ($urandom_range(9) == 0) return PIX_W'($urandom());
    return $urandom_range(1) ? 8'hFF : 8'h00;
  endfunction

  // One frame: pixels, optional stray drains, then the tail; optional hold-off midway.
  task automatic run_frame(int m, int big, int w, int h, int bv, bit noisy, bit hold);
    int npix, tail;
    setup(m, big, w, h, bv);
    npix = sb.eff_w() * sb.eff_h();
    tail = sb.pass_count() * (sb.eff_w() + 1);
    for (int i = 0; i < npix; i++) begin
      if (noisy && $urandom_range(7) == 0) send_request(OP_DRAIN, PIX_W'($urandom()));
      if (hold && i == npix / 2) drain_wait();
      send_request(OP_PIXEL, mask_pixel());
    end
    for (int i = 0; i < tail; i++) begin
      if (noisy && $urandom_range(3) == 0) send_request(OP_PIXEL, PIX_W'($urandom()));
      else send_request(OP_DRAIN, PIX_W'($urandom()));
    end
    drain_wait();
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 10;
    recv_idle_pct = 66;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_PIXEL;
    in_pixel_in = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every mode, tiny frames, borders at both extremes.
    run_frame(MODE_ERODE, 0, 1, 1, 255, 1, 0);
    run_frame(MODE_DILATE, 1, 0, 0, 0, 1, 0);
    run_frame(MODE_OPEN, 0, 3, 2, 255, 1, 0);
    run_frame(MODE_CLOSE, 1, 2, 2, 0, 1, 1);
    // Index past the register list: no effect.
    write_reg(REG_NONE, 0, 'h0);
    // Aborted tall frame: a few pixels, then reconfigure while idle.
    setup(MODE_ERODE, 0, 1, 4095, 128);
    for (int i = 0; i < 10; i++) send_request(OP_PIXEL, mask_pixel());
    drain_wait();

    for (int f = 0; f < 12; f++) begin
      if (f == 4) begin
        send_idle_pct = 66;
        recv_idle_pct = 10;
      end else if (f == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_frame($urandom_range(3), $urandom_range(1), $urandom_range(1, 7),
                $urandom_range(1, 6), $urandom_range(3) == 0 ? 255 :
                ($urandom_range(2) == 0 ? $urandom_range(255) : 0),
                $urandom_range(1), f == 6);
    end
    // Width above the line store clamps to its size: the first results
    // come one clamped row plus one after the frame start.
    setup(MODE_DILATE, 0, 2047, 2, 0);
    for (int i = 0; i < 1030; i++) send_request(OP_PIXEL, mask_pixel());
    drain_wait();

    if (sb.errors == 0) begin
      $display("binary_morphology_3x3_stream regression: pass");
    end else begin
      $display("binary_morphology_3x3_stream regression: fail");
    end
    $finish;
  end

endmodule
